/* rtl/sdtq_pkg.sv */
// Shared types, sizes and codes for the sorted deadline timer queue.
// No dependencies; every other file in rtl/ except sdtq_ram imports this package.
package sdtq_pkg;

    localparam int CAPACITY  = 16;
    localparam int TIME_BITS = 32;
    localparam int HANDLE_W  = 8;
    localparam int TV_W      = 32;   // width of the time_value field on the port
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ENTRY_W   = TIME_BITS + HANDLE_W;

    localparam int S_TDATA_W = HANDLE_W + TV_W;
    localparam int M_TDATA_W = HANDLE_W;
    localparam int M_TUSER_W = 1 + STATUS_W;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [TIME_BITS-1:0] tstamp_t;
    typedef logic [HANDLE_W-1:0]  handle_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_ADJ  = 2'd2,
        MODE_TICK = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEL_RD,
        ST_DEL_EV,
        ST_INS_RD,
        ST_INS_EV,
        ST_INS_WR,
        ST_TCK_RD,
        ST_TCK_EV,
        ST_TCK_END,
        ST_SHF_RD,
        ST_SHF_EV,
        ST_RESP
    } state_t;

    typedef struct packed {
        tstamp_t deadline;
        handle_t handle;
    } entry_t;

    typedef struct packed {
        tstamp_t entry_dl;
        tstamp_t key_dl;
        logic    swap;      // 1: key < entry, 0: entry < key
        handle_t entry_h;
        handle_t key_h;
    } cmp_req_t;

    typedef struct packed {
        logic lt;
        logic hit;
    } cmp_res_t;

    typedef struct packed {
        logic   we;
        idx_t   waddr;
        entry_t wdata;
        logic   re;
        idx_t   raddr;
    } ram_req_t;

    typedef struct packed {
        logic    valid;
        handle_t handle;
        logic    fired;
        status_t status;
        logic    last;
    } emit_t;

endpackage

/* rtl/sdtq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sdtq_cmp.sv */
// Shared compare unit: one magnitude compare on deadlines, one handle match.
// Depends on sdtq_pkg.
module sdtq_cmp (
    input  sdtq_pkg::cmp_req_t req,
    output sdtq_pkg::cmp_res_t res
);
    import sdtq_pkg::*;

    tstamp_t op_a;
    tstamp_t op_b;

    always_comb begin
        op_a    = req.swap ? req.key_dl : req.entry_dl;
        op_b    = req.swap ? req.entry_dl : req.key_dl;
        res.lt  = (op_a < op_b);
        res.hit = (req.entry_h == req.key_h);
    end

endmodule

/* rtl/sdtq_seq.sv */
// Sequencer: walks the sorted list in RAM one entry per read/evaluate pair.
// Depends on sdtq_pkg; drives sdtq_ram and sdtq_cmp through structs.
module sdtq_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sdtq_pkg::MODE_W-1:0]         s_tuser,
    input  logic [sdtq_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                out_free,
    input  sdtq_pkg::entry_t                    rdata,
    input  sdtq_pkg::cmp_res_t                  cmp_res,
    output sdtq_pkg::cmp_req_t                  cmp_req,
    output sdtq_pkg::ram_req_t                  ram_req,
    output sdtq_pkg::emit_t                     emit
);
    import sdtq_pkg::*;

    state_t  state_reg, state_next;
    mode_t   mode_reg, mode_next;
    handle_t key_h_reg, key_h_next;
    tstamp_t key_dl_reg, key_dl_next;
    cnt_t    occ_reg, occ_next;
    cnt_t    idx_reg, idx_next;
    cnt_t    due_reg, due_next;
    logic    found_reg, found_next;
    logic    pend_reg, pend_next;
    handle_t pend_h_reg, pend_h_next;
    status_t status_reg, status_next;

    mode_t   in_mode;
    cnt_t    idx_m1;
    cnt_t    shf_dst;
    logic    at_end;
    logic    full;

    assign in_mode = mode_t'(s_tuser);
    assign idx_m1  = idx_reg - CNT_W'(1);
    assign shf_dst = idx_reg - due_reg;
    assign at_end  = (idx_reg == occ_reg);
    assign full    = (occ_reg == CNT_W'(CAPACITY));
    assign s_tready = (state_reg == ST_IDLE);

    // insert: lt = entry < key; tick: lt = now < entry, i.e. entry not due
    always_comb begin
        cmp_req.entry_dl = rdata.deadline;
        cmp_req.key_dl   = key_dl_reg;
        cmp_req.swap     = (mode_reg == MODE_TICK);
        cmp_req.entry_h  = rdata.handle;
        cmp_req.key_h    = key_h_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        key_h_reg  <= key_h_next;
        key_dl_reg <= key_dl_next;
        idx_reg    <= idx_next;
        due_reg    <= due_next;
        found_reg  <= found_next;
        pend_reg   <= pend_next;
        pend_h_reg <= pend_h_next;
        status_reg <= status_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_mode)
                        MODE_ADD:           state_next = full ? ST_RESP : ST_INS_RD;
                        MODE_DEL, MODE_ADJ: state_next = ST_DEL_RD;
                        MODE_TICK:          state_next = ST_TCK_RD;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DEL_RD: begin
                if (at_end) begin
                    state_next = (found_reg && mode_reg == MODE_ADJ) ? ST_INS_RD : ST_RESP;
                end else begin
                    state_next = ST_DEL_EV;
                end
            end
            ST_DEL_EV:  state_next = ST_DEL_RD;
            ST_INS_RD:  state_next = (idx_reg == '0) ? ST_INS_WR : ST_INS_EV;
            ST_INS_EV:  state_next = cmp_res.lt ? ST_INS_WR : ST_INS_RD;
            ST_INS_WR:  state_next = ST_RESP;
            ST_TCK_RD:  state_next = at_end ? ST_TCK_END : ST_TCK_EV;
            ST_TCK_EV: begin
                if (cmp_res.lt) begin
                    state_next = ST_TCK_END;
                end else if (!pend_reg || out_free) begin
                    state_next = ST_TCK_RD;
                end
            end
            ST_TCK_END: begin
                if (out_free) begin
                    state_next = (idx_reg == '0) ? ST_IDLE : ST_SHF_RD;
                end
            end
            ST_SHF_RD:  state_next = at_end ? ST_IDLE : ST_SHF_EV;
            ST_SHF_EV:  state_next = ST_SHF_RD;
            ST_RESP:    state_next = out_free ? ST_IDLE : ST_RESP;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        mode_next   = mode_reg;
        key_h_next  = key_h_reg;
        key_dl_next = key_dl_reg;
        occ_next    = occ_reg;
        idx_next    = idx_reg;
        due_next    = due_reg;
        found_next  = found_reg;
        pend_next   = pend_reg;
        pend_h_next = pend_h_reg;
        status_next = status_reg;
        ram_req     = '0;
        emit        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next   = in_mode;
                    key_h_next  = s_tdata[HANDLE_W-1:0];
                    key_dl_next = TIME_BITS'(s_tdata[HANDLE_W+TV_W-1:HANDLE_W]);
                    idx_next    = (in_mode == MODE_ADD) ? occ_reg : '0;
                    found_next  = 1'b0;
                    pend_next   = 1'b0;
                    status_next = (in_mode == MODE_ADD && full) ? STAT_FULL : STAT_OK;
                end
            end
            ST_DEL_RD: begin
                if (at_end) begin
                    if (found_reg) begin
                        occ_next = occ_reg - CNT_W'(1);
                        idx_next = occ_reg - CNT_W'(1);
                    end else begin
                        status_next = STAT_MISS;
                    end
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg[IDX_W-1:0];
                end
            end
            ST_DEL_EV: begin
                // after the match, every later entry slides down one slot
                if (found_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = idx_m1[IDX_W-1:0];
                    ram_req.wdata = rdata;
                end else if (cmp_res.hit) begin
                    found_next = 1'b1;
                end
                idx_next = idx_reg + CNT_W'(1);
            end
            ST_INS_RD: begin
                if (idx_reg != '0) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_m1[IDX_W-1:0];
                end
            end
            ST_INS_EV: begin
                // walk from the tail, moving up every entry not earlier than the key
                if (!cmp_res.lt) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = idx_reg[IDX_W-1:0];
                    ram_req.wdata = rdata;
                    idx_next      = idx_m1;
                end
            end
            ST_INS_WR: begin
                ram_req.we             = 1'b1;
                ram_req.waddr          = idx_reg[IDX_W-1:0];
                ram_req.wdata.deadline = key_dl_reg;
                ram_req.wdata.handle   = key_h_reg;
                occ_next               = occ_reg + CNT_W'(1);
            end
            ST_TCK_RD: begin
                if (!at_end) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg[IDX_W-1:0];
                end
            end
            ST_TCK_EV: begin
                // one-entry lookahead so the final due handle carries last
                if (!cmp_res.lt && (!pend_reg || out_free)) begin
                    emit.valid  = pend_reg;
                    emit.handle = pend_h_reg;
                    emit.fired  = 1'b1;
                    emit.status = STAT_OK;
                    emit.last   = 1'b0;
                    pend_next   = 1'b1;
                    pend_h_next = rdata.handle;
                    idx_next    = idx_reg + CNT_W'(1);
                end
            end
            ST_TCK_END: begin
                if (out_free) begin
                    emit.valid  = 1'b1;
                    emit.handle = pend_reg ? pend_h_reg : '0;
                    emit.fired  = pend_reg;
                    emit.status = STAT_OK;
                    emit.last   = 1'b1;
                    due_next    = idx_reg;
                end
            end
            ST_SHF_RD: begin
                if (at_end) begin
                    occ_next = occ_reg - due_reg;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg[IDX_W-1:0];
                end
            end
            ST_SHF_EV: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = shf_dst[IDX_W-1:0];
                ram_req.wdata = rdata;
                idx_next      = idx_reg + CNT_W'(1);
            end
            ST_RESP: begin
                if (out_free) begin
                    emit.valid  = 1'b1;
                    emit.handle = '0;
                    emit.fired  = 1'b0;
                    emit.status = status_reg;
                    emit.last   = 1'b1;
                end
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

endmodule

/* rtl/sorted_deadline_timer_queue.sv */
// Top level of the sorted deadline timer queue: RAM, compare unit, sequencer,
// output register. Depends on sdtq_pkg, sdtq_ram, sdtq_cmp and sdtq_seq.
//
//  channel | dir | tdata (low bit up)            | tuser (low bit up)    | tlast
//  --------+-----+-------------------------------+-----------------------+------
//  s_      | in  | handle[7:0], time_value[39:8] | mode[1:0]             | -
//  m_      | out | expired_handle[7:0]           | fired[0], status[2:1] | last
//
// One operation at a time. Every list entry visited takes a RAM read, then an
// evaluate in the shared compare unit, because the entry RAM has a single
// registered read port.
//   add:          walks from the tail, moving each entry not earlier than the
//                 new one up a slot, then writes the new entry
//   delete:       walks all n entries, n = occupancy; adjust adds an insert when found
//   tick:         reports the d due timers, then compacts the n-d entries that
//                 stay queued when d > 0
// Result stalls on m_tready hold the sequencer at the transfer it is making.
// Reset clears state, occupancy and output valid only; RAM contents are never read unwritten.
module sorted_deadline_timer_queue (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sdtq_pkg::S_TDATA_W-1:0]     s_tdata,   // handle, time_value
    input  logic [sdtq_pkg::MODE_W-1:0]        s_tuser,   // mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sdtq_pkg::M_TDATA_W-1:0]     m_tdata,   // expired_handle
    output logic [sdtq_pkg::M_TUSER_W-1:0]     m_tuser,   // fired, status
    output logic                               m_tlast    // last
);
    import sdtq_pkg::*;

    ram_req_t ram_req;
    entry_t   ram_rdata;
    cmp_req_t cmp_req;
    cmp_res_t cmp_res;
    emit_t    emit;
    logic     out_free;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0] m_user_reg, m_user_next;
    logic                 m_last_reg, m_last_next;

    sdtq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    sdtq_cmp u_cmp (
        .req (cmp_req),
        .res (cmp_res)
    );

    sdtq_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .out_free (out_free),
        .rdata    (ram_rdata),
        .cmp_res  (cmp_res),
        .cmp_req  (cmp_req),
        .ram_req  (ram_req),
        .emit     (emit)
    );

    // the register can take a result when empty or when its transfer completes now
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (emit.valid) begin
            m_valid_next = 1'b1;
            m_data_next  = emit.handle;
            m_user_next  = {emit.status, emit.fired};
            m_last_next  = emit.last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/sdtq_checker.sv */
// Port-level assertions for the sorted deadline timer queue, bound to the top.
// Depends on sdtq_pkg and sorted_deadline_timer_queue.
module sdtq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sdtq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sdtq_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import sdtq_pkg::*;

    // an expired timer always reports ok
    a_fired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == STAT_OK)
        else $error("fired result with nonzero status");

    // a result without a handle closes its operation and carries handle zero
    a_unfired_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == '0)
        else $error("unfired result not last or with nonzero handle");

    // the input is not ready in the cycle after an accepted request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
